@@ rtl/core/lcdse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdse_pkg
// Shared types, constants and segment tables of the LCD status encoder.
// ----------------------------------------------------------------------------
package lcdse_pkg;

    // Number of write frames per snapshot and the width of the frame index
    localparam int unsigned NUM_FRAMES = 6;
    localparam int unsigned FRAME_IDX_W = 3;

    // Level above which a bar display shows empty
    localparam logic [2:0] MAX_BAR_LEVEL = 3'd5;

    // Fixed segment bits
    localparam logic [7:0] SEG_HUNDREDS     = 8'h10;
    localparam logic [7:0] SEG_BATT_FRAME   = 8'h04;
    localparam logic [7:0] SEG_NET_LOGO     = 8'h80;
    localparam logic [7:0] SEG_NET_BAR2     = 8'h20;
    localparam logic [7:0] SEG_NET_BAR1     = 8'h40;
    localparam logic [7:0] SEG_LIGHT        = 8'h08;
    localparam logic [7:0] SEG_PHOTO        = 8'h08;
    localparam logic [7:0] SEG_VIDEO        = 8'h08;
    localparam logic [7:0] SEG_THROTTLE     = 8'h04;
    localparam logic [7:0] SEG_TRIM         = 8'h02;
    localparam logic [7:0] SEG_DUAL_RATE    = 8'h01;
    localparam logic [7:0] SEG_MODE_ONE     = 8'h10;
    localparam logic [7:0] SEG_MODE_TWO     = 8'h20;
    localparam logic [7:0] SEG_PAREN        = 8'h80;
    localparam logic [7:0] SEG_PAREN_PAIR   = 8'hC0;
    localparam logic [7:0] SEG_POINTS       = 8'h0F;

    // Icon codes
    localparam logic [1:0] THR_NONE      = 2'd0;
    localparam logic [1:0] THR_THROTTLE  = 2'd1;
    localparam logic [1:0] THR_TRIM      = 2'd2;
    localparam logic [1:0] THR_DUAL_RATE = 2'd3;
    localparam logic [1:0] CAM_PHOTO     = 2'd1;
    localparam logic [1:0] CAM_VIDEO     = 2'd2;
    localparam logic [1:0] MODE_ONE      = 2'd1;
    localparam logic [1:0] MODE_TWO      = 2'd2;

    // Configuration register index
    localparam logic REG_FRAME_MARKS = 1'b0;

    // One status snapshot
    typedef struct packed {
        logic [7:0] percent;
        logic       text_mode;
        logic [6:0] tens_char;
        logic [6:0] units_char;
        logic [2:0] battery_level;
        logic [2:0] signal_level;
        logic [1:0] throttle_icon;
        logic [1:0] camera_icon;
        logic       light_on;
        logic [1:0] flight_mode;
    } snapshot_t;

    // Segment bytes in emission order: entry 0 goes out first (buffer 5)
    typedef logic [NUM_FRAMES-1:0][7:0] frames_t;

    // Seven-segment pattern of a decimal digit
    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h7D;
            4'd1:    s = 7'h30;
            4'd2:    s = 7'h6B;
            4'd3:    s = 7'h7A;
            4'd4:    s = 7'h36;
            4'd5:    s = 7'h5E;
            4'd6:    s = 7'h5F;
            4'd7:    s = 7'h70;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7E;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Seven-segment pattern of an uppercase letter; anything else is blank
    function automatic logic [6:0] letter_seg(input logic [6:0] c);
        logic [6:0] s;
        case (c)
            7'h41:   s = 7'h77;
            7'h42:   s = 7'h1F;
            7'h43:   s = 7'h4D;
            7'h44:   s = 7'h2B;
            7'h45:   s = 7'h4F;
            7'h46:   s = 7'h47;
            7'h47:   s = 7'h7E;
            7'h48:   s = 7'h37;
            7'h49:   s = 7'h30;
            7'h4A:   s = 7'h38;
            7'h4B:   s = 7'h57;
            7'h4C:   s = 7'h0D;
            7'h4D:   s = 7'h75;
            7'h4E:   s = 7'h13;
            7'h4F:   s = 7'h33;
            7'h50:   s = 7'h67;
            7'h51:   s = 7'h6F;
            7'h52:   s = 7'h03;
            7'h53:   s = 7'h5E;
            7'h54:   s = 7'h0F;
            7'h55:   s = 7'h19;
            7'h56:   s = 7'h3D;
            7'h57:   s = 7'h3D;
            7'h58:   s = 7'h37;
            7'h59:   s = 7'h3E;
            7'h5A:   s = 7'h6B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Battery bar segments; levels above five show none
    function automatic logic [7:0] battery_bars(input logic [2:0] lvl);
        logic [7:0] s;
        case (lvl)
            3'd1:    s = 8'h10;
            3'd2:    s = 8'h30;
            3'd3:    s = 8'h70;
            3'd4:    s = 8'h72;
            3'd5:    s = 8'h73;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Network bars held in buffer 0; levels above five show none
    function automatic logic [7:0] signal_low_bars(input logic [2:0] lvl);
        logic [7:0] s;
        case (lvl)
            3'd3:    s = 8'h04;
            3'd4:    s = 8'h06;
            3'd5:    s = 8'h07;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage : lcdse_pkg
`default_nettype wire

@@ rtl/core/lcdse_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdse_encoder
// Builds the six segment bytes of one snapshot, ordered buffer 5 down to 0.
// ----------------------------------------------------------------------------
module lcdse_encoder
    import lcdse_pkg::*;
(
    input  wire snapshot_t snap,
    input  wire logic      marks_en,
    output frames_t        frames
);

    logic [7:0]  pct_rem1;
    logic [6:0]  pct_rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens_digit;
    logic [7:0]  tens_times10;
    logic [3:0]  units_digit;
    logic [6:0]  tseg;
    logic [6:0]  useg;
    logic        sig_ok;
    logic [7:0]  b0, b1, b2, b3, b4, b5;

    // Split percent into hundreds remainder, tens and units
    always_comb
    begin
        pct_rem1     = (snap.percent >= 8'd200) ? (snap.percent - 8'd200)
                     : (snap.percent >= 8'd100) ? (snap.percent - 8'd100)
                     : snap.percent;
        pct_rem      = pct_rem1[6:0];
        // rem * 205 / 2048 equals rem / 10 for rem below 100
        tens_prod    = 15'(pct_rem) * 15'd205;
        tens_digit   = tens_prod[14:11];
        tens_times10 = 8'(tens_digit) * 8'd10;
        units_digit  = 4'(8'(pct_rem) - tens_times10);
    end

    // Select digit or letter patterns
    always_comb
    begin
        if (snap.text_mode)
        begin
            tseg = letter_seg(snap.tens_char);
            useg = letter_seg(snap.units_char);
        end
        else
        begin
            tseg = digit_seg(tens_digit);
            useg = digit_seg(units_digit);
        end
    end

    assign sig_ok = (snap.signal_level <= MAX_BAR_LEVEL);

    // Assemble the six buffers
    always_comb
    begin
        b0 = signal_low_bars(snap.signal_level);
        if (snap.light_on)
            b0 = b0 | SEG_LIGHT;
        if (marks_en)
            b0 = b0 | SEG_PAREN;

        b1 = SEG_BATT_FRAME | battery_bars(snap.battery_level);
        if (snap.camera_icon == CAM_PHOTO)
            b1 = b1 | SEG_PHOTO;
        if (marks_en)
            b1 = b1 | SEG_PAREN;

        b2 = {tseg[2:0], 5'b0};
        if (!snap.text_mode && (snap.percent >= 8'd100))
            b2 = b2 | SEG_HUNDREDS;
        case (snap.throttle_icon)
            THR_THROTTLE:  b2 = b2 | SEG_THROTTLE;
            THR_TRIM:      b2 = b2 | SEG_TRIM;
            THR_DUAL_RATE: b2 = b2 | SEG_DUAL_RATE;
            default:       b2 = b2;
        endcase
        if (snap.camera_icon == CAM_VIDEO)
            b2 = b2 | SEG_VIDEO;

        b3 = {useg[2:0], 1'b0, tseg[6:3]};

        b4 = {4'b0, useg[6:3]};
        if (sig_ok && (snap.signal_level >= 3'd2))
            b4 = b4 | SEG_NET_BAR2;
        if (marks_en)
            b4 = b4 | SEG_PAREN_PAIR;

        b5 = SEG_NET_LOGO;
        if (sig_ok && (snap.signal_level >= 3'd1))
            b5 = b5 | SEG_NET_BAR1;
        if (snap.flight_mode == MODE_ONE)
            b5 = b5 | SEG_MODE_ONE;
        else if (snap.flight_mode == MODE_TWO)
            b5 = b5 | SEG_MODE_TWO;
        if (marks_en)
            b5 = b5 | SEG_POINTS;

        frames = {b0, b1, b2, b3, b4, b5};
    end

endmodule : lcdse_encoder
`default_nettype wire

@@ rtl/core/lcd_status_segment_encoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_status_segment_encoder_top
// Turns one status snapshot into six LCD segment-RAM write frames.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     in_valid/in_ready    percent .. flight_mode (one snapshot)
// output    out_valid/out_ready  lcd_address, segment_data, last_frame
// config    APB psel/penable     frame_marks_enable at address 0
//
// Each snapshot is registered, encoded combinationally into a six-byte frame
// buffer, then shifted out one frame per cycle while out_ready is high. The
// next snapshot waits in the input register and loads as the last frame is
// taken, so frames flow without gaps.
// Reset clears all valid flags and sets frame_marks_enable. A stall on the
// output holds the current frame; input is taken while the input register
// is empty or about to move into the frame buffer.
// ----------------------------------------------------------------------------
module lcd_status_segment_encoder_top
    import lcdse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // snapshot channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  percent,
    input  wire logic        text_mode,
    input  wire logic [6:0]  tens_char,
    input  wire logic [6:0]  units_char,
    input  wire logic [2:0]  battery_level,
    input  wire logic [2:0]  signal_level,
    input  wire logic [1:0]  throttle_icon,
    input  wire logic [1:0]  camera_icon,
    input  wire logic        light_on,
    input  wire logic [1:0]  flight_mode,
    // frame channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       lcd_address,
    output logic [7:0]       segment_data,
    output logic             last_frame,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                   marks_en_reg;
    logic                   snap_valid_reg;
    snapshot_t              snap_reg;
    logic                   fb_valid_reg;
    frames_t                fb_reg;
    frames_t                fb_next;
    logic [FRAME_IDX_W-1:0] frame_idx_reg;
    frames_t                enc_frames;
    logic                   in_fire;
    logic                   out_fire;
    logic                   fb_load;
    logic                   cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAME_MARKS);
    assign prdata    = (paddr[2] == REG_FRAME_MARKS) ? {31'b0, marks_en_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marks_en_reg <= 1'b1;
        else if (cfg_write)
            marks_en_reg <= pwdata[0];
    end

    // Handshake control
    assign out_valid  = fb_valid_reg;
    assign last_frame = (frame_idx_reg == FRAME_IDX_W'(NUM_FRAMES - 1));
    assign out_fire   = out_valid && out_ready;
    assign fb_load    = snap_valid_reg && (!fb_valid_reg || (out_fire && last_frame));
    assign in_ready   = !snap_valid_reg || fb_load;
    assign in_fire    = in_valid && in_ready;

    // Encode the held snapshot
    lcdse_encoder u_encoder (
        .snap     (snap_reg),
        .marks_en (marks_en_reg),
        .frames   (enc_frames)
    );

    // Valid flags and frame index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            fb_valid_reg   <= 1'b0;
            frame_idx_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                snap_valid_reg <= 1'b1;
            else if (fb_load)
                snap_valid_reg <= 1'b0;

            if (fb_load)
            begin
                fb_valid_reg  <= 1'b1;
                frame_idx_reg <= '0;
            end
            else if (out_fire)
            begin
                if (last_frame)
                begin
                    fb_valid_reg  <= 1'b0;
                    frame_idx_reg <= '0;
                end
                else
                begin
                    frame_idx_reg <= frame_idx_reg + 1'b1;
                end
            end
        end
    end

    // Load or shift the frame buffer
    always_comb
    begin
        if (fb_load)
            fb_next = enc_frames;
        else if (out_fire)
            fb_next = {8'b0, fb_reg[NUM_FRAMES-1:1]};
        else
            fb_next = fb_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            snap_reg.percent       <= percent;
            snap_reg.text_mode     <= text_mode;
            snap_reg.tens_char     <= tens_char;
            snap_reg.units_char    <= units_char;
            snap_reg.battery_level <= battery_level;
            snap_reg.signal_level  <= signal_level;
            snap_reg.throttle_icon <= throttle_icon;
            snap_reg.camera_icon   <= camera_icon;
            snap_reg.light_on      <= light_on;
            snap_reg.flight_mode   <= flight_mode;
        end
        fb_reg <= fb_next;
    end

    assign lcd_address  = {frame_idx_reg, 1'b0};
    assign segment_data = fb_reg[0];

    // Frame index never passes the last frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_idx_reg <= FRAME_IDX_W'(NUM_FRAMES - 1)))
        else $error("frame index out of range");

    // A taken non-final frame advances the address by two
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_frame) |=> (lcd_address == $past(lcd_address) + 4'd2))
        else $error("frame address did not advance");

    // Input stalls only while a snapshot waits behind a busy frame buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (snap_valid_reg && fb_valid_reg))
        else $error("input stalled without a waiting snapshot");

    // Final frame taken with nothing waiting empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_frame && !snap_valid_reg) |=> !out_valid)
        else $error("output stayed valid after final frame");

endmodule : lcd_status_segment_encoder_top
`default_nettype wire
